// ----- src/spdt_pkg.sv -----
// ----------------------------------------------------------------------------
// spdt_pkg
// Shared types and constants for the sensor packet deframer and value table.
// ----------------------------------------------------------------------------
`default_nettype none

package spdt_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;

    localparam int BYTE_W    = 8;
    localparam int VALUE_W   = 32;
    localparam int CNT_W     = 32;
    localparam int APB_W     = 32;
    localparam int ADDR_W    = 4;
    localparam int POS_W     = 12;
    localparam int END_POS_W = 11;
    localparam int GRP_W     = 9;
    localparam int LANE_W    = 3;

    localparam logic [POS_W-1:0]     POS_MAX      = '1;
    localparam logic [POS_W-1:0]     MIN_PACKET   = 12'd6;
    localparam logic [END_POS_W-1:0] END_POS_BASE = 11'd5;
    localparam logic [GRP_W-1:0]     GRP_MAX      = 9'd256;
    localparam logic [LANE_W-1:0]    LANE_LAST    = 3'd4;
    localparam logic [VALUE_W-1:0]   NOT_FOUND_BITS = 32'hC479_C000;

    typedef enum logic [0:0] {
        OP_BYTE   = 1'b0,
        OP_LOOKUP = 1'b1
    } op_t;

    typedef enum logic [0:0] {
        KIND_VERDICT = 1'b0,
        KIND_LOOKUP  = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        REG_START   = 2'd0,
        REG_VERSION = 2'd1,
        REG_END     = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_COMMIT = 2'd1,
        ST_SCAN   = 2'd2
    } state_t;

    typedef struct packed {
        logic              done;
        logic              accepted;
        logic              bad_end;
        logic [BYTE_W-1:0] n;
    } verdict_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  id;
        logic [VALUE_W-1:0] value;
    } staged_t;

endpackage

`default_nettype wire

// ----- src/spdt_req_if.sv -----
// ----------------------------------------------------------------------------
// spdt_req_if
// Request channel: packet bytes and lookup requests with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface spdt_req_if;
    logic                           valid;
    logic                           ready;
    logic                           op;
    logic [spdt_pkg::BYTE_W-1:0]    data_byte;
    logic                           last_byte;
    logic [spdt_pkg::BYTE_W-1:0]    query_id;

    modport source (output valid, op, data_byte, last_byte, query_id, input ready);
    modport sink   (input valid, op, data_byte, last_byte, query_id, output ready);
endinterface

`default_nettype wire

// ----- src/spdt_rsp_if.sv -----
// ----------------------------------------------------------------------------
// spdt_rsp_if
// Response channel: packet verdicts and lookup answers with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface spdt_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           kind;
    logic                           packet_accepted;
    logic                           found;
    logic [spdt_pkg::VALUE_W-1:0]   value_bits;
    logic [spdt_pkg::CNT_W-1:0]     good_packets;
    logic [spdt_pkg::CNT_W-1:0]     bad_end_packets;

    modport source (output valid, kind, packet_accepted, found, value_bits, good_packets,
                    bad_end_packets, input ready);
    modport sink   (input valid, kind, packet_accepted, found, value_bits, good_packets,
                    bad_end_packets, output ready);
endinterface

`default_nettype wire

// ----- src/sensor_packet_deframer_table_core.sv -----
// ----------------------------------------------------------------------------
// sensor_packet_deframer_table_core
// Sensor packet deframer with a lookup table of sensor values, APB config.
// ----------------------------------------------------------------------------
// packet byte: taken on each request handshake; the verdict transaction is valid the cycle after the last byte
// accepted packet: a commit of n = min(count, TABLE_ENTRIES) entries then holds ready low
//   while it runs, one table write per cycle through the single table write port
// lookup: answered without a table read on an empty table, else by sequential
//   table reads through the shared index counter and id compare
// reset: async active low; markers, counters and live count clear, table reads as empty
`default_nettype none

module sensor_packet_deframer_table_core #(
    parameter int TABLE_ENTRIES = spdt_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    spdt_req_if.sink                            req,
    spdt_rsp_if.source                          rsp,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [spdt_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [spdt_pkg::APB_W-1:0]     pwdata,
    output logic [spdt_pkg::APB_W-1:0]          prdata,
    output logic                                pready
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic [spdt_pkg::BYTE_W-1:0]    start_reg, version_reg, end_reg;
    logic                           cfg_we, req_acc, byte_acc, lookup_acc, idle;
    spdt_pkg::reg_idx_t             reg_sel;
    spdt_pkg::verdict_t             verdict;
    spdt_pkg::staged_t              stg_rd;
    logic [IDX_W-1:0]               stg_rd_idx;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign reg_sel = spdt_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg   <= '0;
            version_reg <= '0;
            end_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (reg_sel)
                spdt_pkg::REG_START:   start_reg   <= pwdata[spdt_pkg::BYTE_W-1:0];
                spdt_pkg::REG_VERSION: version_reg <= pwdata[spdt_pkg::BYTE_W-1:0];
                spdt_pkg::REG_END:     end_reg     <= pwdata[spdt_pkg::BYTE_W-1:0];
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            spdt_pkg::REG_START:   prdata = spdt_pkg::APB_W'(start_reg);
            spdt_pkg::REG_VERSION: prdata = spdt_pkg::APB_W'(version_reg);
            spdt_pkg::REG_END:     prdata = spdt_pkg::APB_W'(end_reg);
            default:               prdata = '0;
        endcase
    end

    // one response slot; a new transaction needs it free or freeing this cycle
    assign req.ready  = idle && (!rsp.valid || rsp.ready);
    assign req_acc    = req.valid && req.ready;
    assign byte_acc   = req_acc && (req.op == spdt_pkg::OP_BYTE);
    assign lookup_acc = req_acc && (req.op == spdt_pkg::OP_LOOKUP);

    spdt_frame_rx #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_frame_rx (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_acc     (byte_acc),
        .data_byte    (req.data_byte),
        .last_byte    (req.last_byte),
        .start_marker (start_reg),
        .version_code (version_reg),
        .end_marker   (end_reg),
        .rd_idx       (stg_rd_idx),
        .stg_rd       (stg_rd),
        .verdict      (verdict)
    );

    spdt_table_engine #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_table_engine (
        .clk             (clk),
        .rst_n           (rst_n),
        .lookup_acc      (lookup_acc),
        .query_id        (req.query_id),
        .verdict         (verdict),
        .stg_rd          (stg_rd),
        .stg_rd_idx      (stg_rd_idx),
        .idle            (idle),
        .out_ready       (rsp.ready),
        .out_valid       (rsp.valid),
        .kind            (rsp.kind),
        .packet_accepted (rsp.packet_accepted),
        .found           (rsp.found),
        .value_bits      (rsp.value_bits),
        .good_packets    (rsp.good_packets),
        .bad_end_packets (rsp.bad_end_packets)
    );

endmodule

`default_nettype wire

// ----- src/spdt_frame_rx.sv -----
// ----------------------------------------------------------------------------
// spdt_frame_rx
// Byte parser: header checks, entry staging store and end-of-packet verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module spdt_frame_rx #(
    parameter int  TABLE_ENTRIES = spdt_pkg::TABLE_ENTRIES_DEF,
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           byte_acc,
    input  wire logic [spdt_pkg::BYTE_W-1:0]    data_byte,
    input  wire logic                           last_byte,
    input  wire logic [spdt_pkg::BYTE_W-1:0]    start_marker,
    input  wire logic [spdt_pkg::BYTE_W-1:0]    version_code,
    input  wire logic [spdt_pkg::BYTE_W-1:0]    end_marker,
    input  wire logic [IDX_W-1:0]               rd_idx,
    output spdt_pkg::staged_t                   stg_rd,
    output spdt_pkg::verdict_t                  verdict
);

    logic [spdt_pkg::POS_W-1:0]     pos_reg, pos_next, pos_inc;
    logic                           hdr_bad_reg, hdr_bad_next, t_hdr;
    logic [spdt_pkg::BYTE_W-1:0]    count_reg, count_next, t_count;
    logic [spdt_pkg::END_POS_W-1:0] end_pos_reg, end_pos_next, t_end_pos;
    logic [spdt_pkg::BYTE_W-1:0]    end_seen_reg, end_seen_next, t_end_seen;
    logic [spdt_pkg::GRP_W-1:0]     grp_reg, grp_next, t_grp;
    logic [spdt_pkg::LANE_W-1:0]    lane_reg, lane_next, t_lane;
    logic                           stage_hit, stg_we, frame_ok;
    logic [1:0]                     lane_sel;

    logic [spdt_pkg::BYTE_W-1:0]    stg_id_mem  [TABLE_ENTRIES];
    logic [spdt_pkg::VALUE_W-1:0]   stg_val_mem [TABLE_ENTRIES];
    spdt_pkg::staged_t              stg_rd_reg;

    always_comb
    begin
        pos_inc    = (pos_reg == spdt_pkg::POS_MAX) ? pos_reg
                                                     : pos_reg + spdt_pkg::POS_W'(1);
        t_hdr      = hdr_bad_reg;
        t_count    = count_reg;
        t_end_pos  = end_pos_reg;
        t_end_seen = end_seen_reg;
        t_grp      = grp_reg;
        t_lane     = lane_reg;
        stage_hit  = 1'b0;
        if (pos_reg == spdt_pkg::POS_W'(0))
        begin
            if (data_byte != start_marker)
                t_hdr = 1'b1;
        end
        else if (pos_reg == spdt_pkg::POS_W'(1))
        begin
            if (data_byte != version_code)
                t_hdr = 1'b1;
        end
        else if (pos_reg == spdt_pkg::POS_W'(2))
        begin
            // end position is 5 + 5 * count
            t_count   = data_byte;
            t_end_pos = ({3'b000, data_byte} << 2) + {3'b000, data_byte}
                        + spdt_pkg::END_POS_BASE;
        end
        else
        begin
            stage_hit = (grp_reg < {1'b0, count_reg})
                        && (grp_reg < spdt_pkg::GRP_W'(TABLE_ENTRIES));
            if (pos_reg == {1'b0, end_pos_reg})
                t_end_seen = data_byte;
            if (lane_reg == spdt_pkg::LANE_LAST)
            begin
                t_lane = '0;
                if (grp_reg != spdt_pkg::GRP_MAX)
                    t_grp = grp_reg + spdt_pkg::GRP_W'(1);
            end
            else
            begin
                t_lane = lane_reg + spdt_pkg::LANE_W'(1);
            end
        end

        stg_we   = byte_acc && stage_hit;
        lane_sel = 2'(lane_reg - spdt_pkg::LANE_W'(1));

        frame_ok = (pos_inc >= spdt_pkg::MIN_PACKET) && !t_hdr
                   && (pos_inc > {1'b0, t_end_pos});
        verdict.done     = byte_acc && last_byte;
        verdict.accepted = verdict.done && frame_ok && (t_end_seen == end_marker);
        verdict.bad_end  = verdict.done && frame_ok && (t_end_seen != end_marker);
        verdict.n        = (t_count > spdt_pkg::BYTE_W'(TABLE_ENTRIES))
                           ? spdt_pkg::BYTE_W'(TABLE_ENTRIES) : t_count;

        pos_next      = pos_reg;
        hdr_bad_next  = hdr_bad_reg;
        count_next    = count_reg;
        end_pos_next  = end_pos_reg;
        end_seen_next = end_seen_reg;
        grp_next      = grp_reg;
        lane_next     = lane_reg;
        if (byte_acc && last_byte)
        begin
            pos_next      = '0;
            hdr_bad_next  = 1'b0;
            count_next    = '0;
            end_pos_next  = spdt_pkg::END_POS_BASE;
            end_seen_next = '0;
            grp_next      = '0;
            lane_next     = '0;
        end
        else if (byte_acc)
        begin
            pos_next      = pos_inc;
            hdr_bad_next  = t_hdr;
            count_next    = t_count;
            end_pos_next  = t_end_pos;
            end_seen_next = t_end_seen;
            grp_next      = t_grp;
            lane_next     = t_lane;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            hdr_bad_reg  <= 1'b0;
            count_reg    <= '0;
            end_pos_reg  <= spdt_pkg::END_POS_BASE;
            end_seen_reg <= '0;
            grp_reg      <= '0;
            lane_reg     <= '0;
        end
        else
        begin
            pos_reg      <= pos_next;
            hdr_bad_reg  <= hdr_bad_next;
            count_reg    <= count_next;
            end_pos_reg  <= end_pos_next;
            end_seen_reg <= end_seen_next;
            grp_reg      <= grp_next;
            lane_reg     <= lane_next;
        end
    end

    // staging store, value bytes arrive least significant first
    always_ff @(posedge clk)
    begin
        if (stg_we && (lane_reg == '0))
            stg_id_mem[grp_reg[IDX_W-1:0]] <= data_byte;
        if (stg_we && (lane_reg != '0))
            stg_val_mem[grp_reg[IDX_W-1:0]][{lane_sel, 3'b000} +: spdt_pkg::BYTE_W] <= data_byte;
        stg_rd_reg.id    <= stg_id_mem[rd_idx];
        stg_rd_reg.value <= stg_val_mem[rd_idx];
    end

    assign stg_rd = stg_rd_reg;

endmodule

`default_nettype wire

// ----- src/spdt_table_engine.sv -----
// ----------------------------------------------------------------------------
// spdt_table_engine
// Table sequencer: one index counter and compare shared by commit and lookup
// scan, the sensor table memory, packet counters and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module spdt_table_engine #(
    parameter int  TABLE_ENTRIES = spdt_pkg::TABLE_ENTRIES_DEF,
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           lookup_acc,
    input  wire logic [spdt_pkg::BYTE_W-1:0]    query_id,
    input  wire spdt_pkg::verdict_t             verdict,
    input  wire spdt_pkg::staged_t              stg_rd,
    output logic [IDX_W-1:0]                    stg_rd_idx,
    output logic                                idle,
    input  wire logic                           out_ready,
    output logic                                out_valid,
    output logic                                kind,
    output logic                                packet_accepted,
    output logic                                found,
    output logic [spdt_pkg::VALUE_W-1:0]        value_bits,
    output logic [spdt_pkg::CNT_W-1:0]          good_packets,
    output logic [spdt_pkg::CNT_W-1:0]          bad_end_packets
);

    spdt_pkg::state_t               state_reg, state_next;
    logic [spdt_pkg::BYTE_W-1:0]    idx_reg, idx_next;
    logic [spdt_pkg::BYTE_W-1:0]    live_reg, live_next;
    logic [spdt_pkg::BYTE_W-1:0]    q_reg, q_next;
    logic                           issued_reg, issued_next;
    logic                           rd_vld_reg, rd_vld_next;
    logic                           rd_last_reg, rd_last_next;
    logic                           wr_pend_reg, wr_pend_next;
    logic [IDX_W-1:0]               wr_idx_reg;
    logic [spdt_pkg::CNT_W-1:0]     ok_reg, ok_next;
    logic [spdt_pkg::CNT_W-1:0]     err_reg, err_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           kind_reg, acc_reg, found_reg;
    logic [spdt_pkg::VALUE_W-1:0]   value_reg;
    logic [spdt_pkg::CNT_W-1:0]     good_reg, bad_reg;

    logic                           last_issue, hit, issue_scan, res_load;
    logic                           res_kind, res_acc, res_found;
    logic [spdt_pkg::VALUE_W-1:0]   res_value;

    logic [spdt_pkg::BYTE_W-1:0]    tbl_id_mem  [TABLE_ENTRIES];
    logic [spdt_pkg::VALUE_W-1:0]   tbl_val_mem [TABLE_ENTRIES];
    logic [spdt_pkg::BYTE_W-1:0]    tbl_id_rd_reg;
    logic [spdt_pkg::VALUE_W-1:0]   tbl_val_rd_reg;

    assign last_issue = (idx_reg == (live_reg - spdt_pkg::BYTE_W'(1)));
    assign hit        = (tbl_id_rd_reg == q_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            spdt_pkg::ST_IDLE:
            begin
                if (verdict.done && verdict.accepted && (verdict.n != '0))
                    state_next = spdt_pkg::ST_COMMIT;
                else if (lookup_acc && (live_reg != '0))
                    state_next = spdt_pkg::ST_SCAN;
            end
            spdt_pkg::ST_COMMIT:
            begin
                if (last_issue)
                    state_next = spdt_pkg::ST_IDLE;
            end
            spdt_pkg::ST_SCAN:
            begin
                if (rd_vld_reg && (hit || rd_last_reg))
                    state_next = spdt_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = spdt_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        idle         = (state_reg == spdt_pkg::ST_IDLE);
        issue_scan   = (state_reg == spdt_pkg::ST_SCAN) && !issued_reg;
        idx_next     = '0;
        issued_next  = 1'b0;
        rd_vld_next  = issue_scan;
        rd_last_next = issue_scan && last_issue;
        wr_pend_next = (state_reg == spdt_pkg::ST_COMMIT);
        live_next    = live_reg;
        q_next       = q_reg;
        ok_next      = ok_reg;
        err_next     = err_reg;
        res_load     = 1'b0;
        res_kind     = spdt_pkg::KIND_LOOKUP;
        res_acc      = 1'b0;
        res_found    = 1'b0;
        res_value    = spdt_pkg::NOT_FOUND_BITS;

        unique case (state_reg)
            spdt_pkg::ST_IDLE:
            begin
                if (verdict.done)
                begin
                    if (verdict.accepted)
                    begin
                        live_next = verdict.n;
                        ok_next   = ok_reg + spdt_pkg::CNT_W'(1);
                    end
                    if (verdict.bad_end)
                        err_next = err_reg + spdt_pkg::CNT_W'(1);
                    res_load  = 1'b1;
                    res_kind  = spdt_pkg::KIND_VERDICT;
                    res_acc   = verdict.accepted;
                    res_value = '0;
                end
                else if (lookup_acc)
                begin
                    q_next = query_id;
                    if (live_reg == '0)
                        res_load = 1'b1;
                end
            end
            spdt_pkg::ST_COMMIT:
            begin
                idx_next = idx_reg + spdt_pkg::BYTE_W'(1);
            end
            spdt_pkg::ST_SCAN:
            begin
                issued_next = issued_reg || last_issue;
                idx_next    = issue_scan && !last_issue ? idx_reg + spdt_pkg::BYTE_W'(1)
                                                        : idx_reg;
                if (rd_vld_reg && hit)
                begin
                    res_load  = 1'b1;
                    res_found = 1'b1;
                    res_value = tbl_val_rd_reg;
                end
                else if (rd_vld_reg && rd_last_reg)
                begin
                    res_load = 1'b1;
                end
            end
            default:
            begin
                idx_next = '0;
            end
        endcase

        if (res_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;

        stg_rd_idx      = idx_reg[IDX_W-1:0];
        out_valid       = out_valid_reg;
        kind            = kind_reg;
        packet_accepted = acc_reg;
        found           = found_reg;
        value_bits      = value_reg;
        good_packets    = good_reg;
        bad_end_packets = bad_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spdt_pkg::ST_IDLE;
            idx_reg       <= '0;
            live_reg      <= '0;
            issued_reg    <= 1'b0;
            rd_vld_reg    <= 1'b0;
            rd_last_reg   <= 1'b0;
            wr_pend_reg   <= 1'b0;
            ok_reg        <= '0;
            err_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            live_reg      <= live_next;
            issued_reg    <= issued_next;
            rd_vld_reg    <= rd_vld_next;
            rd_last_reg   <= rd_last_next;
            wr_pend_reg   <= wr_pend_next;
            ok_reg        <= ok_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg      <= q_next;
        wr_idx_reg <= idx_reg[IDX_W-1:0];
        if (res_load)
        begin
            kind_reg  <= res_kind;
            acc_reg   <= res_acc;
            found_reg <= res_found;
            value_reg <= res_value;
            good_reg  <= ok_next;
            bad_reg   <= err_next;
        end
    end

    // sensor table, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_pend_reg)
        begin
            tbl_id_mem[wr_idx_reg]  <= stg_rd.id;
            tbl_val_mem[wr_idx_reg] <= stg_rd.value;
        end
        tbl_id_rd_reg  <= tbl_id_mem[idx_reg[IDX_W-1:0]];
        tbl_val_rd_reg <= tbl_val_mem[idx_reg[IDX_W-1:0]];
    end

    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= spdt_pkg::BYTE_W'(TABLE_ENTRIES))
        else $error("live count exceeds table size");

    a_commit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == spdt_pkg::ST_COMMIT) |-> (live_reg != '0))
        else $error("commit running with empty live count");

    a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_pend_reg |-> (spdt_pkg::BYTE_W'(wr_idx_reg) < live_reg))
        else $error("table write beyond live count");

    a_scan_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == spdt_pkg::ST_SCAN) && res_load) |-> !out_valid_reg)
        else $error("lookup answer would overwrite a pending transaction");

    a_ok_step: assert property (@(posedge clk) disable iff (!rst_n)
        (ok_reg != $past(ok_reg)) |-> (ok_reg == $past(ok_reg) + spdt_pkg::CNT_W'(1)))
        else $error("good packet counter jumped");

endmodule

`default_nettype wire
